>>> src/mos_pkg.sv
// Package for the median-of-sample-set block: default sizes and the
// per-cell control bundle. No dependencies.
`default_nettype none
package mos_pkg;

   // Default store depth and sample width
   localparam int MAX_LEN_DEF      = 16;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // Control handed from the top level to each cell of the sort chain
   typedef struct packed {
      logic load;      // a sample is inserted this cycle
      logic occupied;  // this cell holds a stored sample
      logic at_tail;   // this cell is the first free slot
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> src/mos_cell.sv
// One cell of the insertion-sort chain: holds one sample and shifts up
// when a smaller sample is inserted below it. Uses mos_pkg.
`default_nettype none
module mos_cell #(
   parameter int SAMPLE_WIDTH = mos_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire mos_pkg::cell_ctrl_type      ctrl,
   input  wire logic signed [SAMPLE_WIDTH-1:0] new_sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] prev_value,
   input  wire logic                        prev_gt,
   output logic signed [SAMPLE_WIDTH-1:0]   value,
   output logic                             gt
);

   logic signed [SAMPLE_WIDTH-1:0] value_ff;
   logic signed [SAMPLE_WIDTH-1:0] value_in;

   // Cell is occupied and its stored sample is strictly greater than the one being inserted
   assign gt    = ctrl.occupied && (value_ff > new_sample);
   assign value = value_ff;

   // Take the neighbor's value if it moves up, else the new sample
   always_comb begin
      value_in = value_ff;
      if (ctrl.load && (gt || ctrl.at_tail)) begin
         value_in = prev_gt ? prev_value : new_sample;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

>>> src/median_of_sample_set.sv
// Top level of the median-of-sample-set block: sort chain of mos_cell
// instances, set bookkeeping and median output. Uses mos_pkg.
//
// Usage:
//   Samples enter on req_sample/req_last; a transfer happens at a rising
//   edge with start high and busy low. Each sample is inserted into a
//   chain of MAX_LEN cells kept in ascending order, one sample per cycle
//   while busy is low. A transfer with req_last high closes the set:
//   busy is high for the next cycle while the two middle cells are
//   selected and summed, and the result appears in the cycle after that
//   on rsp_median_times_two and rsp_overflowed with rsp_strobe high for
//   exactly one cycle.
//   Samples arriving with the chain full are dropped and reported by
//   rsp_overflowed on the set's result.
//   The result is twice the median (sum of the two middle samples for
//   an even count), so it is exact.
//   Reset (synchronous, active high) empties the set and clears the
//   strobe; the sample cells themselves are not cleared.
//   The receiver cannot stall: each result is taken in its strobe cycle.
`default_nettype none
module median_of_sample_set #(
   parameter int MAX_LEN      = mos_pkg::MAX_LEN_DEF,
   parameter int SAMPLE_WIDTH = mos_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                           req_last,
   output logic                                rsp_strobe,
   output logic signed [SAMPLE_WIDTH:0]        rsp_median_times_two,
   output logic                                rsp_overflowed
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_LEN);

   // Set bookkeeping
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             fin_ff, fin_in;
   logic [CNT_W-1:0] fin_count_ff, fin_count_in;
   logic             fin_ovf_ff, fin_ovf_in;

   // Result registers
   logic                      strobe_ff, strobe_in;
   logic signed [SAMPLE_WIDTH:0] med_ff, med_in;
   logic                      med_ovf_ff, med_ovf_in;

   logic accept;
   logic full;
   logic load;

   // Cell chain wiring
   logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_LEN];
   logic                           cell_gt    [MAX_LEN];
   mos_pkg::cell_ctrl_type         cell_ctrl  [MAX_LEN];

   assign busy   = fin_ff;
   assign accept = start && !busy;
   assign full   = (count_ff == FULL_CNT);
   assign load   = accept && !full;

   // Sort chain
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] prev_value;
      logic                           prev_gt;

      if (i == 0) begin : g_head
         assign prev_value = req_sample;
         assign prev_gt    = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_gt    = cell_gt[i-1];
      end

      assign cell_ctrl[i].load     = load;
      assign cell_ctrl[i].occupied = (CNT_W'(i) < count_ff);
      assign cell_ctrl[i].at_tail  = (CNT_W'(i) == count_ff);

      mos_cell #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .new_sample(req_sample),
         .prev_value(prev_value),
         .prev_gt   (prev_gt),
         .value     (cell_value[i]),
         .gt        (cell_gt[i])
      );
   end

   // Set state: count, overflow flag, snapshot at the final transfer
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      fin_in       = 1'b0;
      fin_count_in = fin_count_ff;
      fin_ovf_in   = fin_ovf_ff;
      if (accept) begin
         if (req_last) begin
            count_in     = '0;
            ovf_in       = 1'b0;
            fin_in       = 1'b1;
            fin_count_in = full ? count_ff : count_ff + CNT_W'(1);
            fin_ovf_in   = ovf_ff || full;
         end else if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // Median: pick the two middle cells and add them
   logic [CNT_W-1:0]             lo_idx, hi_idx;
   logic [SAMPLE_WIDTH-1:0]      lo_val, hi_val;

   assign lo_idx = (fin_count_ff - CNT_W'(1)) >> 1;
   assign hi_idx = fin_count_ff >> 1;

   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < MAX_LEN; i++) begin
         lo_val = lo_val | (cell_value[i] & {SAMPLE_WIDTH{CNT_W'(i) == lo_idx}});
         hi_val = hi_val | (cell_value[i] & {SAMPLE_WIDTH{CNT_W'(i) == hi_idx}});
      end
   end

   always_comb begin
      strobe_in  = fin_ff;
      med_in     = med_ff;
      med_ovf_in = med_ovf_ff;
      if (fin_ff) begin
         med_in     = $signed({lo_val[SAMPLE_WIDTH-1], lo_val})
                    + $signed({hi_val[SAMPLE_WIDTH-1], hi_val});
         med_ovf_in = fin_ovf_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         fin_ff    <= fin_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fin_count_ff <= fin_count_in;
      fin_ovf_ff   <= fin_ovf_in;
      med_ff       <= med_in;
      med_ovf_ff   <= med_ovf_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_median_times_two = med_ff;
   assign rsp_overflowed       = med_ovf_ff;

endmodule
`default_nettype wire
